/* sv/packet_timestamp_ring_tracker_defines.svh */
// Assertion macros for the packet timestamp ring tracker.
`ifndef PACKET_TIMESTAMP_RING_TRACKER_DEFINES_SVH
`define PACKET_TIMESTAMP_RING_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTRT_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("ptrt assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PTRT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("ptrt assertion failed");

`endif

/* sv/ptrt_pkg.sv */
// Shared types, codes and ring helpers for the packet timestamp ring tracker.
`timescale 1ns / 1ps
`default_nettype none

package ptrt_pkg;

  localparam int DEPTH  = 256;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int DIST_W = PTR_W + 1;
  localparam int CNT_W  = 8;
  localparam int SEQ_W  = 32;
  localparam int TIME_W = 64;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [DIST_W-1:0] dist_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [SEQ_W-1:0]  seq_t;
  typedef logic [TIME_W-1:0] time_t;
  typedef logic [1:0]        op_t;
  typedef logic [1:0]        status_t;

  localparam op_t OP_SEND = 2'd0;
  localparam op_t OP_ACK  = 2'd1;
  localparam op_t OP_TAKE = 2'd2;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_NOT_FOUND = 2'd1;
  localparam status_t ST_DUP       = 2'd2;

  // Write request into the ring storage.
  typedef struct packed {
    logic  en_all;   // send: seq, sent and recv
    logic  en_recv;  // ack match: recv only
    ptr_t  addr;
    seq_t  seq;
    time_t sent;
    time_t recv;
  } ptrt_wr_t;

  // One ring entry as read back.
  typedef struct packed {
    seq_t  seq;
    time_t sent;
    time_t recv;
  } ptrt_entry_t;

  function automatic ptr_t ring_next(input ptr_t p);
    ptr_t r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + ptr_t'(1);
    end
    return r;
  endfunction

  function automatic dist_t ring_dist(input ptr_t to, input ptr_t from);
    dist_t r;
    if (to >= from) begin
      r = {1'b0, to} - {1'b0, from};
    end else begin
      r = {1'b0, to} + DIST_W'(DEPTH) - {1'b0, from};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/packet_timestamp_ring_tracker.sv */
// Top level of the packet timestamp ring tracker: sequencer, pointers, result register.
`timescale 1ns / 1ps
`default_nettype none

`include "packet_timestamp_ring_tracker_defines.svh"

// Packet timestamp ring tracker. A transaction is taken when start is high
// and busy is low. Each transaction yields exactly one result, shown on the
// out_ ports for a single cycle while out_valid is high; the receiver cannot
// stall it, so capture it on that cycle. Timing: a send or an unused op code
// completes while busy stays low, and its result strobes on the next
// cycle. A take holds busy through one registered memory read. An ack
// holds busy through a first read and then one compare per ring entry examined
// (1 up to the in-flight count) by the one sequence comparator walking the
// ring through the single memory read port, one entry per cycle; an ack with
// nothing in flight answers without a scan, busy staying low. The result strobes on the cycle
// after the transaction's last cycle, and a new transaction may be taken in that
// same cycle. Ring storage has no reset: taking an entry that was never
// written returns undefined data.
module packet_timestamp_ring_tracker (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire ptrt_pkg::op_t     in_op,
  input  wire ptrt_pkg::time_t   in_timestamp,
  input  wire ptrt_pkg::time_t   in_now_us,
  input  wire ptrt_pkg::seq_t    in_ack_seq,
  output logic                   out_valid,
  output ptrt_pkg::status_t      out_status,
  output ptrt_pkg::seq_t         out_seq_out,
  output ptrt_pkg::time_t        out_sent_time,
  output ptrt_pkg::time_t        out_recv_time,
  output ptrt_pkg::cnt_t         out_in_flight,
  output ptrt_pkg::cnt_t         out_ready_count
);
  import ptrt_pkg::*;

  // Sequencer states.
  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_ACK_RD  = 2'd1;  // first scan read in flight
  localparam logic [1:0] S_ACK_CMP = 2'd2;  // compare one entry, fetch the next
  localparam logic [1:0] S_TAKE    = 2'd3;  // tail entry read data arriving

  logic [1:0] state_r, state_nxt;

  ptr_t send_head_r, send_head_nxt;
  ptr_t ack_head_r,  ack_head_nxt;
  ptr_t tail_ptr_r,  tail_ptr_nxt;
  seq_t next_seq_r,  next_seq_nxt;

  // Ack transaction operands held across the scan.
  time_t ts_r,      ts_nxt;
  seq_t  ack_seq_r, ack_seq_nxt;

  // Result register.
  logic    out_valid_r, out_valid_nxt;
  status_t status_r,    status_nxt;
  seq_t    seq_out_r,   seq_out_nxt;
  time_t   sent_r,      sent_nxt;
  time_t   recv_r,      recv_nxt;
  cnt_t    flight_r,    flight_nxt;
  cnt_t    ready_r,     ready_nxt;

  ptrt_wr_t    wr;
  ptr_t        rd_addr;
  ptrt_entry_t rd_data;
  ptr_t        ack_next;
  logic        accept;
  logic        seq_match;

  ptrt_ring_mem u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign ack_next  = ring_next(ack_head_r);
  // The shared comparator: scanned entry against the acked sequence.
  assign seq_match = (rd_data.seq == ack_seq_r);

  always_comb begin
    state_nxt     = state_r;
    send_head_nxt = send_head_r;
    ack_head_nxt  = ack_head_r;
    tail_ptr_nxt  = tail_ptr_r;
    next_seq_nxt  = next_seq_r;
    ts_nxt        = ts_r;
    ack_seq_nxt   = ack_seq_r;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    seq_out_nxt   = seq_out_r;
    sent_nxt      = sent_r;
    recv_nxt      = recv_r;
    wr            = '0;
    rd_addr       = tail_ptr_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_SEND: begin
              wr.en_all     = 1'b1;
              wr.addr       = send_head_r;
              wr.seq        = next_seq_r;
              wr.sent       = (in_timestamp == '0) ? in_now_us : in_timestamp;
              wr.recv       = '0;
              send_head_nxt = ring_next(send_head_r);
              next_seq_nxt  = next_seq_r + seq_t'(1);
              out_valid_nxt = 1'b1;
              status_nxt    = ST_OK;
              seq_out_nxt   = next_seq_r;
              sent_nxt      = '0;
              recv_nxt      = '0;
            end
            OP_ACK: begin
              ts_nxt      = in_timestamp;
              ack_seq_nxt = in_ack_seq;
              if (ack_head_r == send_head_r) begin
                // nothing in flight
                out_valid_nxt = 1'b1;
                status_nxt    = ST_NOT_FOUND;
                seq_out_nxt   = '0;
                sent_nxt      = '0;
                recv_nxt      = '0;
              end else begin
                state_nxt = S_ACK_RD;
              end
            end
            OP_TAKE: begin
              rd_addr      = tail_ptr_r;
              tail_ptr_nxt = ring_next(tail_ptr_r);
              state_nxt    = S_TAKE;
            end
            default: begin
              // unused op code: no state change
              out_valid_nxt = 1'b1;
              status_nxt    = ST_OK;
              seq_out_nxt   = '0;
              sent_nxt      = '0;
              recv_nxt      = '0;
            end
          endcase
        end
      end
      S_ACK_RD: begin
        rd_addr   = ack_head_r;
        state_nxt = S_ACK_CMP;
      end
      S_ACK_CMP: begin
        // rd_data is the entry at ack_head_r; prefetch the one after it
        rd_addr      = ack_next;
        ack_head_nxt = ack_next;
        if (seq_match) begin
          if (rd_data.recv != '0) begin
            status_nxt = ST_DUP;
          end else begin
            status_nxt = ST_OK;
            wr.en_recv = 1'b1;
            wr.addr    = ack_head_r;
            wr.recv    = ts_r;
          end
          out_valid_nxt = 1'b1;
          seq_out_nxt   = '0;
          sent_nxt      = '0;
          recv_nxt      = '0;
          state_nxt     = S_IDLE;
        end else if (ack_next == send_head_r) begin
          // scanned everything in flight, all dropped
          out_valid_nxt = 1'b1;
          status_nxt    = ST_NOT_FOUND;
          seq_out_nxt   = '0;
          sent_nxt      = '0;
          recv_nxt      = '0;
          state_nxt     = S_IDLE;
        end
      end
      S_TAKE: begin
        out_valid_nxt = 1'b1;
        status_nxt    = ST_OK;
        seq_out_nxt   = rd_data.seq;
        sent_nxt      = rd_data.sent;
        recv_nxt      = rd_data.recv;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Counts reflect the pointers after the transaction.
    flight_nxt = cnt_t'(ring_dist(send_head_nxt, ack_head_nxt));
    ready_nxt  = cnt_t'(ring_dist(ack_head_nxt, tail_ptr_nxt));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      send_head_r <= '0;
      ack_head_r  <= '0;
      tail_ptr_r  <= '0;
      next_seq_r  <= seq_t'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      send_head_r <= send_head_nxt;
      ack_head_r  <= ack_head_nxt;
      tail_ptr_r  <= tail_ptr_nxt;
      next_seq_r  <= next_seq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ts_r      <= ts_nxt;
    ack_seq_r <= ack_seq_nxt;
    if (out_valid_nxt) begin
      status_r  <= status_nxt;
      seq_out_r <= seq_out_nxt;
      sent_r    <= sent_nxt;
      recv_r    <= recv_nxt;
      flight_r  <= flight_nxt;
      ready_r   <= ready_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_seq_out     = seq_out_r;
  assign out_sent_time   = sent_r;
  assign out_recv_time   = recv_r;
  assign out_in_flight   = flight_r;
  assign out_ready_count = ready_r;

  // The scan never stands on the send head.
  `PTRT_ASSERT_NOW(a_scan_in_range, clk, rst_n,
    (state_r == S_ACK_RD) || (state_r == S_ACK_CMP), ack_head_r != send_head_r)
  // A take goes straight to its data cycle.
  `PTRT_ASSERT_NEXT(a_take_seq, clk, rst_n,
    accept && (in_op == OP_TAKE), state_r == S_TAKE)
  // The take data cycle always produces the result strobe.
  `PTRT_ASSERT_NEXT(a_take_result, clk, rst_n,
    state_r == S_TAKE, out_valid_r && (out_status == ST_OK))
  // A send answers on the next cycle with the sequence it consumed.
  `PTRT_ASSERT_NEXT(a_send_result, clk, rst_n,
    accept && (in_op == OP_SEND), out_valid_r && (out_seq_out == $past(next_seq_r)))

endmodule

`default_nettype wire

/* sv/ptrt_ring_mem.sv */
// Ring entry storage: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module ptrt_ring_mem (
  input  wire logic                  clk,
  input  wire ptrt_pkg::ptrt_wr_t    wr,
  input  wire ptrt_pkg::ptr_t        rd_addr,
  output ptrt_pkg::ptrt_entry_t      rd_data
);
  import ptrt_pkg::*;

  seq_t  seq_mem  [DEPTH];
  time_t sent_mem [DEPTH];
  time_t recv_mem [DEPTH];

  seq_t  rd_seq_r;
  time_t rd_sent_r;
  time_t rd_recv_r;

  always_ff @(posedge clk) begin
    if (wr.en_all) begin
      seq_mem[wr.addr]  <= wr.seq;
      sent_mem[wr.addr] <= wr.sent;
    end
    if (wr.en_all || wr.en_recv) begin
      recv_mem[wr.addr] <= wr.recv;
    end
    rd_seq_r  <= seq_mem[rd_addr];
    rd_sent_r <= sent_mem[rd_addr];
    rd_recv_r <= recv_mem[rd_addr];
  end

  assign rd_data = '{seq: rd_seq_r, sent: rd_sent_r, recv: rd_recv_r};

endmodule

`default_nettype wire

/* verif/ring_tracker_checker.sv */
// Checker for the packet timestamp ring tracker: predicts each result and compares it.
`timescale 1ns / 1ps

module ring_tracker_checker
  import ptrt_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  logic    busy,
  input  op_t     in_op,
  input  time_t   in_timestamp,
  input  time_t   in_now_us,
  input  seq_t    in_ack_seq,
  input  logic    out_valid,
  input  status_t out_status,
  input  seq_t    out_seq_out,
  input  time_t   out_sent_time,
  input  time_t   out_recv_time,
  input  cnt_t    out_in_flight,
  input  cnt_t    out_ready_count,
  output int      mismatches,
  output int      results_due
);

  typedef struct packed {
    status_t status;
    seq_t    seq;
    time_t   sent;
    time_t   recv;
    cnt_t    in_flight;
    cnt_t    ready;
  } tracker_result_t;

  // Shadow ring; entries start as zeros, but the stimulus never takes an unwritten one.
  seq_t  seq_mem  [DEPTH];
  time_t sent_mem [DEPTH];
  time_t recv_mem [DEPTH];
  seq_t  nxt_seq;
  int    snd_ptr;
  int    ack_ptr;
  int    tl_ptr;

  tracker_result_t expected_q[$];

  initial begin
    mismatches  = 0;
    results_due = 0;
    for (int i = 0; i < DEPTH; i++) begin
      seq_mem[i]  = '0;
      sent_mem[i] = '0;
      recv_mem[i] = '0;
    end
  end

  function automatic int step_ptr(input int p);
    return (p + 1) % DEPTH;
  endfunction

  function automatic cnt_t span(input int to_p, input int from_p);
    return cnt_t'((to_p - from_p + DEPTH) % DEPTH);
  endfunction

  function automatic tracker_result_t track_item(input op_t op, input time_t ts,
                                                 input time_t now, input seq_t aseq);
    tracker_result_t r;
    int              idx;
    bit              hit;
    r   = '0;
    hit = 1'b0;
    case (op)
      OP_SEND: begin
        seq_mem[snd_ptr]  = nxt_seq;
        sent_mem[snd_ptr] = (ts == '0) ? now : ts;
        recv_mem[snd_ptr] = '0;
        r.seq             = nxt_seq;
        nxt_seq           = nxt_seq + seq_t'(1);
        snd_ptr           = step_ptr(snd_ptr);
      end
      OP_ACK: begin
        // every entry passed before the match counts as dropped
        while (!hit && ack_ptr != snd_ptr) begin
          idx     = ack_ptr;
          ack_ptr = step_ptr(ack_ptr);
          if (seq_mem[idx] == aseq) begin
            hit = 1'b1;
            if (recv_mem[idx] != '0) begin
              r.status = ST_DUP;
            end else begin
              recv_mem[idx] = ts;
            end
          end
        end
        if (!hit) begin
          r.status = ST_NOT_FOUND;
        end
      end
      OP_TAKE: begin
        r.seq  = seq_mem[tl_ptr];
        r.sent = sent_mem[tl_ptr];
        r.recv = recv_mem[tl_ptr];
        tl_ptr = step_ptr(tl_ptr);
      end
      default: ;
    endcase
    r.in_flight = span(snd_ptr, ack_ptr);
    r.ready     = span(ack_ptr, tl_ptr);
    return r;
  endfunction

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    tracker_result_t want;
    if (!rst_n) begin
      nxt_seq = seq_t'(1);
      snd_ptr = 0;
      ack_ptr = 0;
      tl_ptr  = 0;
      expected_q.delete();
    end else begin
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          $error("result with no transaction outstanding");
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          check_field("status", 64'(want.status), 64'(out_status));
          check_field("seq_out", 64'(want.seq), 64'(out_seq_out));
          check_field("sent_time", want.sent, out_sent_time);
          check_field("recv_time", want.recv, out_recv_time);
          check_field("in_flight", 64'(want.in_flight), 64'(out_in_flight));
          check_field("ready_count", 64'(want.ready), 64'(out_ready_count));
        end
      end
      if (start && !busy) begin
        expected_q.push_back(track_item(in_op, in_timestamp, in_now_us, in_ack_seq));
      end
    end
    results_due = expected_q.size();
  end

endmodule

/* verif/tb_top.sv */
// Testbench top for the packet timestamp ring tracker: clock, reset, stimulus, verdict.
`timescale 1ns / 1ps

module tb_top;
  import ptrt_pkg::*;

  // The op field is two bits wide; the fourth code is unused and must be a no-op.
  localparam op_t OP_UNUSED = 2'd3;

  localparam time_t TIME_MAX = '1;
  localparam seq_t  SEQ_MAX  = '1;

  logic    clk;
  logic    rst_n;
  logic    start;
  logic    busy;
  op_t     in_op;
  time_t   in_timestamp;
  time_t   in_now_us;
  seq_t    in_ack_seq;
  logic    out_valid;
  status_t out_status;
  seq_t    out_seq_out;
  time_t   out_sent_time;
  time_t   out_recv_time;
  cnt_t    out_in_flight;
  cnt_t    out_ready_count;

  int mismatches;
  int results_due;

  // Stimulus-side bookkeeping. Only the pointers that move deterministically are
  // tracked here: the send head, the tail and the next sequence number. That is
  // enough to never take an entry that no send has written, and to aim acks at
  // sequences that were actually sent.
  int   sh_send;
  int   sh_tail;
  seq_t sh_seq;
  bit   written [DEPTH];
  int   burst_left;

  packet_timestamp_ring_tracker u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_timestamp   (in_timestamp),
    .in_now_us      (in_now_us),
    .in_ack_seq     (in_ack_seq),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_seq_out    (out_seq_out),
    .out_sent_time  (out_sent_time),
    .out_recv_time  (out_recv_time),
    .out_in_flight  (out_in_flight),
    .out_ready_count(out_ready_count)
  );

  // Watches both channels, keeps its own ring and scores every result.
  ring_tracker_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_timestamp   (in_timestamp),
    .in_now_us      (in_now_us),
    .in_ack_seq     (in_ack_seq),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_seq_out    (out_seq_out),
    .out_sent_time  (out_sent_time),
    .out_recv_time  (out_recv_time),
    .out_in_flight  (out_in_flight),
    .out_ready_count(out_ready_count),
    .mismatches     (mismatches),
    .results_due    (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop. The slowest legal run (every ack scanning a full ring, every
  // gap at its longest) stays far below this.
  initial begin
    #(5_000_000);
    $display("** packet_timestamp_ring_tracker: FAILED **");
    $finish;
  end

  function automatic time_t rand_time();
    return {$urandom, $urandom};
  endfunction

  // Present one transaction on the falling edge and hold it until the block
  // takes it. busy is read right after the rising edge, before the block's
  // own updates land, so it is the value the block itself sampled.
  task automatic issue(input op_t op, input time_t ts, input time_t now, input seq_t aseq);
    @(negedge clk);
    start        <= 1'b1;
    in_op        <= op;
    in_timestamp <= ts;
    in_now_us    <= now;
    in_ack_seq   <= aseq;
    do @(posedge clk); while (busy);
    case (op)
      OP_SEND: begin
        written[sh_send] = 1'b1;
        sh_send          = (sh_send + 1) % DEPTH;
        sh_seq           = sh_seq + seq_t'(1);
      end
      OP_TAKE: sh_tail = (sh_tail + 1) % DEPTH;
      default: ;
    endcase
  endtask

  // Idle cycles with start low; the payload ports carry junk the block must ignore.
  task automatic pause(input int n);
    repeat (n) begin
      @(negedge clk);
      start        <= 1'b0;
      in_op        <= op_t'($urandom);
      in_timestamp <= rand_time();
      in_now_us    <= rand_time();
      in_ack_seq   <= $urandom;
    end
  endtask

  // Sender pacing: bursts of random length separated by random gaps. Every
  // few bursts is a long one, so there are stretches with no idling at all.
  task automatic pace();
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        pause($urandom_range(1, 8));
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 10);
    end
    burst_left--;
  endtask

  // One random transaction. Most acks name one of the last few sequences
  // sent, so scans usually match after skipping a handful of entries; a few
  // name stale sequences (re-acks) or random values, which drain the in-flight
  // window. take_heavy pushes the tail past the ack head and the send head.
  task automatic random_item(input bit take_heavy);
    int    pick;
    int    send_lim;
    int    ack_lim;
    op_t   op;
    time_t ts;
    time_t now;
    seq_t  aseq;
    pick     = $urandom_range(0, 99);
    send_lim = take_heavy ? 25 : 40;
    ack_lim  = take_heavy ? 45 : 68;
    ts       = rand_time();
    now      = rand_time();
    aseq     = $urandom;
    if (pick < send_lim) begin
      op = OP_SEND;
      if ($urandom_range(0, 5) == 0) begin
        ts = '0;  // send time comes from now_us
      end
    end else if (pick < ack_lim) begin
      op   = OP_ACK;
      aseq = sh_seq - seq_t'($urandom_range(1, 4));
      if ($urandom_range(0, 9) == 0) begin
        ts = '0;
      end
    end else if (pick < ack_lim + 4) begin
      op   = OP_ACK;
      aseq = sh_seq - seq_t'($urandom_range(5, 40));
    end else if (pick < ack_lim + 7) begin
      op = OP_ACK;
    end else if (pick < 97) begin
      op = OP_TAKE;
    end else begin
      op = OP_UNUSED;
    end
    // never hand out an entry that no send has written
    if (op == OP_TAKE && !written[sh_tail]) begin
      op = OP_SEND;
    end
    pace();
    issue(op, ts, now, aseq);
  endtask

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_op        = OP_SEND;
    in_timestamp = '0;
    in_now_us    = '0;
    in_ack_seq   = '0;
    sh_send      = 0;
    sh_tail      = 0;
    sh_seq       = seq_t'(1);
    burst_left   = 0;
    for (int i = 0; i < DEPTH; i++) begin
      written[i] = 1'b0;
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, every op, each corner named for the ring.
    issue(OP_UNUSED, '0, '0, '0);                  // unused op right after reset
    issue(OP_ACK, 64'd5, '0, '0);                  // ack with nothing in flight
    issue(OP_SEND, '0, TIME_MAX, '0);              // zero send time -> now_us (seq 1)
    issue(OP_SEND, TIME_MAX, '0, '0);              // seq 2
    issue(OP_SEND, 64'd1, 64'd123, SEQ_MAX);       // seq 3
    issue(OP_SEND, 64'h8000_0000_0000_0000, TIME_MAX, '0);  // seq 4
    issue(OP_ACK, TIME_MAX, '0, seq_t'(2));        // seq 1 skipped as dropped
    issue(OP_ACK, 64'd7, '0, seq_t'(2));           // re-ack: scan drains, not found
    issue(OP_SEND, rand_time(), rand_time(), '0);  // seq 5
    issue(OP_SEND, rand_time(), rand_time(), '0);  // seq 6
    issue(OP_ACK, '0, TIME_MAX, seq_t'(5));        // zero receive time recorded
    issue(OP_ACK, rand_time(), '0, SEQ_MAX);       // unknown sequence drains the rest
    issue(OP_UNUSED, TIME_MAX, TIME_MAX, SEQ_MAX); // unused op, all ones
    repeat (6) issue(OP_TAKE, rand_time(), rand_time(), $urandom);
    issue(OP_SEND, rand_time(), rand_time(), '0);  // seq 7
    issue(OP_TAKE, '0, '0, '0);                    // tail runs past the ack head
    issue(OP_ACK, rand_time(), '0, seq_t'(7));
    issue(OP_UNUSED, '0, '0, '0);

    // Random mix with bursty pacing.
    repeat (60) random_item(1'b0);

    // Long run of sends so the send head laps the ring and overwrites entries.
    repeat (260) begin
      pace();
      issue(OP_SEND, ($urandom_range(0, 7) == 0) ? '0 : rand_time(), rand_time(), $urandom);
    end

    // Every entry is now written; acks face long scans and takes run freely.
    repeat (60) random_item(1'b1);

    pause(1);
    wait (results_due == 0);
    repeat (20) @(posedge clk);

    if (mismatches == 0) begin
      $display("** packet_timestamp_ring_tracker: PASSED **");
    end else begin
      $display("** packet_timestamp_ring_tracker: FAILED **");
    end
    $finish;
  end

endmodule

/* packet_timestamp_ring_tracker.f */
+incdir+sv
sv/ptrt_pkg.sv
sv/ptrt_ring_mem.sv
sv/packet_timestamp_ring_tracker.sv
verif/ring_tracker_checker.sv
verif/tb_top.sv
